FILE: rtl/core/rms_contrast_compare_macros.svh
// Assertion macros for the rms_contrast_compare checker.
// Needs signals named clk and rst_n in the scope where a macro is used.
`ifndef RMS_CONTRAST_COMPARE_MACROS_SVH
`define RMS_CONTRAST_COMPARE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define RCC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define RCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/rcc_pkg.sv
// Package for the RMS contrast comparator: constants, compare codes and the
// command/status structs between controller and datapath. No dependencies.
`default_nettype none

package rcc_pkg;

  localparam int unsigned PIXEL_COUNT_BITS_DEF   = 22;
  localparam int unsigned LUMA_FRACTION_BITS_DEF = 8;

  localparam int unsigned COLOR_W    = 8;
  localparam int unsigned WSUM_W     = 24;
  localparam int unsigned WEIGHT_R   = 13933;
  localparam int unsigned WEIGHT_G   = 46871;
  localparam int unsigned WEIGHT_B   = 4732;
  localparam int unsigned CONTRAST_W = 15;
  localparam int unsigned CONTRAST_MAX = 32767;

  localparam logic [1:0] CMP_FIRST  = 2'd0;
  localparam logic [1:0] CMP_SECOND = 2'd1;
  localparam logic [1:0] CMP_EQUAL  = 2'd2;
  localparam logic [1:0] CMP_NONE   = 2'd3;

  typedef struct packed {
    logic div_start;
    logic div_sel_sq;
    logic cap_mean;
    logic cap_msq;
    logic sqrt_start;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic last_accum;
    logic div_done;
    logic sqrt_done;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/rcc_if.sv
// Valid/ready channel interfaces for pixel input and contrast results.
// Depends on rcc_pkg.
`default_nettype none

interface rcc_in_if;
  import rcc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [COLOR_W-1:0]   red;
  logic [COLOR_W-1:0]   green;
  logic [COLOR_W-1:0]   blue;
  logic                 image_index;
  logic                 last_pixel;

  modport source (output valid, red, green, blue, image_index, last_pixel, input ready);
  modport sink   (input valid, red, green, blue, image_index, last_pixel, output ready);
endinterface

interface rcc_out_if;
  import rcc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CONTRAST_W-1:0] contrast;
  logic                  which_image;
  logic [1:0]            compare_code;

  modport source (output valid, contrast, which_image, compare_code, input ready);
  modport sink   (input valid, contrast, which_image, compare_code, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/rcc_div.sv
// Restoring divider, one quotient bit per cycle, MSB-first over a chosen
// number of dividend bits. Standalone; no package dependency.
`default_nettype none

module rcc_div #(
  parameter int unsigned DIVIDEND_W = 54,
  parameter int unsigned DIVISOR_W  = 23
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic [DIVIDEND_W-1:0]             dividend,
  input  wire logic [$clog2(DIVIDEND_W+1)-1:0]   steps,
  input  wire logic [DIVISOR_W-1:0]              divisor,
  output logic                                   done,
  output logic [DIVIDEND_W-1:0]                  quotient
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_r;
  logic                  done_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [DIVIDEND_W-1:0] dvd_r;
  logic [DIVIDEND_W-1:0] quo_r;
  logic [DIVISOR_W-1:0]  rem_r;
  logic [DIVISOR_W:0]    shifted;
  logic                  ge;
  logic [DIVISOR_W-1:0]  rem_nxt;

  assign shifted = {rem_r, dvd_r[DIVIDEND_W-1]};
  assign ge      = shifted >= {1'b0, divisor};
  assign rem_nxt = ge ? DIVISOR_W'(shifted - {1'b0, divisor}) : shifted[DIVISOR_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DIVIDEND_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DIVIDEND_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

FILE: rtl/core/rcc_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
// Standalone; no package dependency.
`default_nettype none

module rcc_sqrt #(
  parameter int unsigned ROOT_W = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [2*ROOT_W-1:0]   radicand,
  output logic                       done,
  output logic [ROOT_W-1:0]          root
);

  localparam int unsigned CNT_W = $clog2(ROOT_W + 1);

  logic                  busy_r;
  logic                  done_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [2*ROOT_W-1:0]   op_r;
  logic [ROOT_W-1:0]     root_r;
  logic [ROOT_W+1:0]     rem_r;
  logic [ROOT_W+3:0]     shifted;
  logic [ROOT_W+3:0]     trial;
  logic                  ge;
  logic [ROOT_W+1:0]     rem_nxt;

  assign shifted = {rem_r, op_r[2*ROOT_W-1 -: 2]};
  assign trial   = {2'b00, root_r, 2'b01};
  assign ge      = shifted >= trial;
  assign rem_nxt = ge ? (ROOT_W+2)'(shifted - trial) : (ROOT_W+2)'(shifted);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(ROOT_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op_r   <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      op_r   <= {op_r[2*ROOT_W-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= {root_r[ROOT_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

`default_nettype wire

FILE: rtl/core/rcc_datapath.sv
// Datapath: luma pipeline, per-image accumulators, divider, root, compare
// and output register. Depends on rcc_pkg, rcc_div and rcc_sqrt.
`default_nettype none

module rcc_datapath #(
  parameter int unsigned PIXEL_COUNT_BITS   = 22,
  parameter int unsigned LUMA_FRACTION_BITS = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_fire,
  input  wire logic [rcc_pkg::COLOR_W-1:0]   in_red,
  input  wire logic [rcc_pkg::COLOR_W-1:0]   in_green,
  input  wire logic [rcc_pkg::COLOR_W-1:0]   in_blue,
  input  wire logic                          in_image_index,
  input  wire logic                          in_last_pixel,
  input  wire rcc_pkg::dp_cmd_t              cmd,
  output rcc_pkg::dp_sts_t                   sts,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [rcc_pkg::CONTRAST_W-1:0]     out_contrast,
  output logic                               out_which_image,
  output logic [1:0]                         out_compare_code
);

  import rcc_pkg::*;

  localparam int unsigned LW      = COLOR_W + LUMA_FRACTION_BITS;
  localparam int unsigned SQW     = 2 * LW;
  localparam int unsigned CNTW    = PIXEL_COUNT_BITS + 1;
  localparam int unsigned SUMW    = LW + PIXEL_COUNT_BITS;
  localparam int unsigned SQSW    = SQW + PIXEL_COUNT_BITS;
  localparam int unsigned DCNT_W  = $clog2(SQSW + 1);

  logic [WSUM_W-1:0]     wsum;
  logic [LW-1:0]         luma1_r;
  logic                  v1_r;
  logic                  last1_r;
  logic [LW-1:0]         luma2_r;
  logic [SQW-1:0]        sq2_r;
  logic                  v2_r;
  logic                  last2_r;
  logic                  last3_r;
  logic [CNTW-1:0]       tally_r;
  logic [SUMW-1:0]       sum_r;
  logic [SQSW-1:0]       sqsum_r;
  logic                  idx_r;
  logic [LW-1:0]         mean_r;
  logic [SQW-1:0]        mean_sq_r;
  logic [SQW-1:0]        msq_r;
  logic [SQW-1:0]        var_val;
  logic [SQSW-1:0]       div_dividend;
  logic [DCNT_W-1:0]     div_steps;
  logic                  div_done;
  logic [SQSW-1:0]       div_quo;
  logic                  sqrt_done;
  logic [LW-1:0]         root;
  logic [CONTRAST_W-1:0] contrast_sat;
  logic [1:0]            code;
  logic [CONTRAST_W-1:0] first_contrast_r;
  logic                  first_done_r;
  logic                  out_valid_r;
  logic [CONTRAST_W-1:0] out_contrast_r;
  logic                  out_which_r;
  logic [1:0]            out_code_r;

  assign wsum = WSUM_W'(WEIGHT_R) * WSUM_W'(in_red)
              + WSUM_W'(WEIGHT_G) * WSUM_W'(in_green)
              + WSUM_W'(WEIGHT_B) * WSUM_W'(in_blue);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      last1_r <= 1'b0;
      last2_r <= 1'b0;
      last3_r <= 1'b0;
    end else begin
      v1_r    <= in_fire;
      last1_r <= in_fire & in_last_pixel;
      v2_r    <= v1_r;
      last2_r <= last1_r;
      last3_r <= v2_r & last2_r;
    end
  end

  always_ff @(posedge clk) begin
    luma1_r <= wsum[WSUM_W-1 -: LW];
    luma2_r <= luma1_r;
    sq2_r   <= luma1_r * luma1_r;
    if (in_fire && in_last_pixel) begin
      idx_r <= in_image_index;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load_out) begin
      tally_r <= '0;
      sum_r   <= '0;
      sqsum_r <= '0;
    end else if (v2_r && !tally_r[PIXEL_COUNT_BITS]) begin
      tally_r <= tally_r + CNTW'(1);
      sum_r   <= sum_r + SUMW'(luma2_r);
      sqsum_r <= sqsum_r + SQSW'(sq2_r);
    end
  end

  assign div_dividend = cmd.div_sel_sq ? sqsum_r : {sum_r, LW'(0)};
  assign div_steps    = cmd.div_sel_sq ? DCNT_W'(SQSW) : DCNT_W'(SUMW);

  rcc_div #(
    .DIVIDEND_W (SQSW),
    .DIVISOR_W  (CNTW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .steps    (div_steps),
    .divisor  (tally_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (cmd.cap_mean) begin
      mean_r <= div_quo[LW-1:0];
    end
    if (cmd.cap_msq) begin
      msq_r <= div_quo[SQW-1:0];
    end
    mean_sq_r <= mean_r * mean_r;
  end

  assign var_val = (msq_r >= mean_sq_r) ? (msq_r - mean_sq_r) : '0;

  rcc_sqrt #(
    .ROOT_W (LW)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sqrt_start),
    .radicand (var_val),
    .done     (sqrt_done),
    .root     (root)
  );

  assign contrast_sat = (32'(root) > 32'(CONTRAST_MAX)) ? CONTRAST_W'(CONTRAST_MAX)
                                                        : CONTRAST_W'(root);

  always_comb begin
    if (!idx_r || !first_done_r) begin
      code = CMP_NONE;
    end else if (first_contrast_r > contrast_sat) begin
      code = CMP_FIRST;
    end else if (contrast_sat > first_contrast_r) begin
      code = CMP_SECOND;
    end else begin
      code = CMP_EQUAL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_contrast_r <= '0;
      first_done_r     <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
        if (!idx_r) begin
          first_contrast_r <= contrast_sat;
          first_done_r     <= 1'b1;
        end else begin
          first_done_r <= 1'b0;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_contrast_r <= contrast_sat;
      out_which_r    <= idx_r;
      out_code_r     <= code;
    end
  end

  assign sts.last_accum = last3_r;
  assign sts.div_done   = div_done;
  assign sts.sqrt_done  = sqrt_done;
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_contrast     = out_contrast_r;
  assign out_which_image  = out_which_r;
  assign out_compare_code = out_code_r;

endmodule

`default_nettype wire

FILE: rtl/core/rcc_ctrl.sv
// Controller: streams pixels, then sequences the divides, the root and the
// result hand-off for each finished image. Depends on rcc_pkg.
`default_nettype none

module rcc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_fire,
  input  wire logic              in_last_pixel,
  output logic                   in_ready,
  input  wire rcc_pkg::dp_sts_t  sts,
  output rcc_pkg::dp_cmd_t       cmd
);

  import rcc_pkg::*;

  typedef enum logic [6:0] {
    S_ACC     = 7'b0000001,
    S_DRAIN   = 7'b0000010,
    S_DIV_SUM = 7'b0000100,
    S_DIV_SQ  = 7'b0001000,
    S_VAR     = 7'b0010000,
    S_SQRT    = 7'b0100000,
    S_DONE    = 7'b1000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_ACC: begin
        in_ready = 1'b1;
        if (in_fire && in_last_pixel) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (sts.last_accum) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV_SUM;
        end
      end
      S_DIV_SUM: begin
        if (sts.div_done) begin
          cmd.cap_mean   = 1'b1;
          cmd.div_start  = 1'b1;
          cmd.div_sel_sq = 1'b1;
          state_nxt      = S_DIV_SQ;
        end
      end
      S_DIV_SQ: begin
        if (sts.div_done) begin
          cmd.cap_msq = 1'b1;
          state_nxt   = S_VAR;
        end
      end
      S_VAR: begin
        cmd.sqrt_start = 1'b1;
        state_nxt      = S_SQRT;
      end
      S_SQRT: begin
        if (sts.sqrt_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_ACC;
        end
      end
      default: begin
        state_nxt = S_ACC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_ACC;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/rms_contrast_compare.sv
// Top level of the RMS contrast comparator: controller plus datapath.
// Depends on rcc_pkg, rcc_if, rcc_ctrl and rcc_datapath.
//
//   channel   dir  handshake      payload
//   in_chan   in   valid/ready    red, green, blue, image_index, last_pixel
//   out_chan  out  valid/ready    contrast, which_image, compare_code
//
// Pixels are taken one per cycle while an image streams in.
// After a last pixel the input stalls for the drain, the divides of the luma sum (LUMA+COUNT
// bits) and the square sum (2*LUMA+COUNT bits), a variance state, a LUMA-bit root (the divides
// and the root each at one bit per cycle) and the load state.
// A stalled result holds the load cycle; otherwise the result register frees the core.
// Reset is synchronous, active low, and empties all accumulators.
`default_nettype none

module rms_contrast_compare #(
  parameter int unsigned PIXEL_COUNT_BITS   = rcc_pkg::PIXEL_COUNT_BITS_DEF,
  parameter int unsigned LUMA_FRACTION_BITS = rcc_pkg::LUMA_FRACTION_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rcc_in_if.sink     in_chan,
  rcc_out_if.source  out_chan
);

  import rcc_pkg::*;

  logic    in_ready;
  logic    in_fire;
  dp_cmd_t cmd;
  dp_sts_t sts;

  assign in_fire       = in_chan.valid & in_ready;
  assign in_chan.ready = in_ready;

  rcc_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_fire       (in_fire),
    .in_last_pixel (in_chan.last_pixel),
    .in_ready      (in_ready),
    .sts           (sts),
    .cmd           (cmd)
  );

  rcc_datapath #(
    .PIXEL_COUNT_BITS   (PIXEL_COUNT_BITS),
    .LUMA_FRACTION_BITS (LUMA_FRACTION_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_fire          (in_fire),
    .in_red           (in_chan.red),
    .in_green         (in_chan.green),
    .in_blue          (in_chan.blue),
    .in_image_index   (in_chan.image_index),
    .in_last_pixel    (in_chan.last_pixel),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_chan.valid),
    .out_ready        (out_chan.ready),
    .out_contrast     (out_chan.contrast),
    .out_which_image  (out_chan.which_image),
    .out_compare_code (out_chan.compare_code)
  );

endmodule

`default_nettype wire

FILE: rtl/core/rcc_checker.sv
// Port-level checker for rms_contrast_compare, bound to the top level.
// Depends on rcc_pkg and rms_contrast_compare_macros.svh.
`default_nettype none
`include "rms_contrast_compare_macros.svh"

module rcc_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_ready,
  input wire logic                              in_last_pixel,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic [rcc_pkg::CONTRAST_W-1:0]    out_contrast,
  input wire logic                              out_which_image,
  input wire logic [1:0]                        out_compare_code
);

  import rcc_pkg::*;

  `RCC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_contrast) && $stable(out_which_image) && $stable(out_compare_code), "result changed while stalled")
  `RCC_ASSERT_NEXT(a_stall_after_last, in_valid && in_ready && in_last_pixel, !in_ready, "input taken during image finish")
  `RCC_ASSERT_NOW(a_first_no_compare, out_valid && !out_which_image, out_compare_code == CMP_NONE, "first image result carries a comparison")

endmodule

bind rms_contrast_compare rcc_checker u_rcc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_chan.valid),
  .in_ready         (in_chan.ready),
  .in_last_pixel    (in_chan.last_pixel),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_contrast     (out_chan.contrast),
  .out_which_image  (out_chan.which_image),
  .out_compare_code (out_chan.compare_code)
);

`default_nettype wire
